/* hdl/assert_macros.svh */
// assertion macros shared by the rtl of the risk cell classifier
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define RCC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define RCC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rcc_pkg.sv */
// shared types and constants of the risk cell classifier
// no dependencies
package rcc_pkg;

	typedef logic [1:0] status_t;
	typedef logic [1:0] rule_t;
	typedef logic [1:0] reg_index_t;

	// cell status codes
	localparam status_t STATUS_LOW   = 2'd0;
	localparam status_t STATUS_HIGH  = 2'd1;
	localparam status_t STATUS_TIE   = 2'd2;
	localparam status_t STATUS_EMPTY = 2'd3;

	// tie and empty cell rule codes, any other code means unclassified or skip
	localparam rule_t RULE_LOW  = 2'd0;
	localparam rule_t RULE_HIGH = 2'd1;

	// configuration register indexes
	localparam reg_index_t REG_THRESHOLD  = 2'd0;
	localparam reg_index_t REG_TIE_RULE   = 2'd1;
	localparam reg_index_t REG_EMPTY_RULE = 2'd2;

	localparam int THRESHOLD_BITS = 32;
	localparam int FRAC_BITS      = 16;
	localparam int CFG_DATA_BITS  = 32;
	localparam int RULE_BITS      = 2;

	localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 32'h0001_0000;
	localparam rule_t TIE_RULE_RESET   = 2'd2;
	localparam rule_t EMPTY_RULE_RESET = 2'd2;

	// decision for one cell, passed from classification to the totals
	typedef struct packed {
		status_t status;
		logic    add_high;
		logic    add_low;
	} class_t;

endpackage

/* hdl/rcc_classify.sv */
// ratio test of one cell against the q16.16 threshold, plus tie and empty rules
// depends on rcc_pkg
module rcc_classify #(
	parameter int COUNT_BITS = 20
) (
	input  logic [rcc_pkg::THRESHOLD_BITS-1:0] threshold,
	input  rcc_pkg::rule_t                     tie_rule,
	input  rcc_pkg::rule_t                     empty_rule,
	input  logic [COUNT_BITS-1:0]              train_unaffected,
	input  logic [COUNT_BITS-1:0]              train_affected,
	output rcc_pkg::class_t                    cls
);
	import rcc_pkg::*;

	localparam int PROD_BITS = THRESHOLD_BITS + COUNT_BITS;

	logic [PROD_BITS-1:0] lhs;
	logic [PROD_BITS-1:0] rhs;
	logic                 empty_cell;

	// affected * 2^16 against threshold * unaffected, exact
	assign lhs = PROD_BITS'(train_affected) << FRAC_BITS;
	assign rhs = PROD_BITS'(threshold) * PROD_BITS'(train_unaffected);
	assign empty_cell = (train_unaffected == '0) && (train_affected == '0);

	always_comb begin
		cls = '0;
		if (empty_cell) begin
			cls.status   = STATUS_EMPTY;
			cls.add_high = (empty_rule == RULE_HIGH);
			cls.add_low  = (empty_rule == RULE_LOW);
		end else begin
			if (train_unaffected == '0 || lhs > rhs) begin
				cls.status = STATUS_HIGH;
			end else if (lhs < rhs) begin
				cls.status = STATUS_LOW;
			end else begin
				case (tie_rule)
					RULE_LOW:  cls.status = STATUS_LOW;
					RULE_HIGH: cls.status = STATUS_HIGH;
					default:   cls.status = STATUS_TIE;
				endcase
			end
			cls.add_high = (cls.status == STATUS_HIGH);
			cls.add_low  = (cls.status == STATUS_LOW);
		end
	end

endmodule

/* hdl/rcc_totals.sv */
// four saturating running totals and their output registers
// depends on rcc_pkg
module rcc_totals #(
	parameter int COUNT_BITS = 20,
	parameter int TOTAL_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  rcc_pkg::class_t       cls,
	input  logic [COUNT_BITS-1:0] test_unaffected,
	input  logic [COUNT_BITS-1:0] test_affected,
	input  logic                  last,
	output logic [TOTAL_BITS-1:0] class_high_total,
	output logic [TOTAL_BITS-1:0] misclass_high_total,
	output logic [TOTAL_BITS-1:0] class_low_total,
	output logic [TOTAL_BITS-1:0] misclass_low_total
);
	import rcc_pkg::*;

	localparam int SUM_BITS = ((TOTAL_BITS > COUNT_BITS) ? TOTAL_BITS : COUNT_BITS) + 1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	logic [TOTAL_BITS-1:0] ch_acc_q, mh_acc_q, cl_acc_q, ml_acc_q;
	logic [TOTAL_BITS-1:0] ch_next, mh_next, cl_next, ml_next;
	logic [TOTAL_BITS-1:0] ch_out_q, mh_out_q, cl_out_q, ml_out_q;

	function automatic logic [TOTAL_BITS-1:0] sat_add(
		input logic [TOTAL_BITS-1:0] acc,
		input logic [COUNT_BITS-1:0] val
	);
		logic [SUM_BITS-1:0] s;
		s = SUM_BITS'(acc) + SUM_BITS'(val);
		if (s > SUM_BITS'(TOTAL_MAX)) begin
			return TOTAL_MAX;
		end
		return s[TOTAL_BITS-1:0];
	endfunction

	always_comb begin
		ch_next = cls.add_high ? sat_add(ch_acc_q, test_affected)   : ch_acc_q;
		mh_next = cls.add_high ? sat_add(mh_acc_q, test_unaffected) : mh_acc_q;
		cl_next = cls.add_low  ? sat_add(cl_acc_q, test_unaffected) : cl_acc_q;
		ml_next = cls.add_low  ? sat_add(ml_acc_q, test_affected)   : ml_acc_q;
	end

	// the result shows totals with this cell, the state clears after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_acc_q <= '0;
			mh_acc_q <= '0;
			cl_acc_q <= '0;
			ml_acc_q <= '0;
		end else if (load) begin
			ch_acc_q <= last ? '0 : ch_next;
			mh_acc_q <= last ? '0 : mh_next;
			cl_acc_q <= last ? '0 : cl_next;
			ml_acc_q <= last ? '0 : ml_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch_out_q <= ch_next;
			mh_out_q <= mh_next;
			cl_out_q <= cl_next;
			ml_out_q <= ml_next;
		end
	end

	assign class_high_total    = ch_out_q;
	assign misclass_high_total = mh_out_q;
	assign class_low_total     = cl_out_q;
	assign misclass_low_total  = ml_out_q;

endmodule

/* hdl/risk_cell_classifier.sv */
// risk cell classifier top level: input register, classification stage, totals
// depends on rcc_pkg, rcc_classify, rcc_totals and assert_macros.svh
//
// One transaction on the input channel (in_valid/in_ready) carries one model
// cell: its index, training and testing counts and the last_cell mark. Each
// cell gives exactly one transaction on the output channel (out_valid/
// out_ready) with the echoed id, the cell status and the four running totals
// as they stand after that cell; final_result repeats last_cell, and the
// totals restart from zero with the following cell.
// The block takes one cell every cycle as long as the receiver does not stall:
// input register, a stage holding the single threshold multiply and compare,
// then the totals adders feeding the output register. When the receiver
// stalls, the output holds and the two inner stages keep filling, so in_ready
// falls only once all three stages are full.
// The configuration port (cfg_wr_en, cfg_index, cfg_data) writes the
// threshold, tie rule and empty cell rule; write it only while the block is
// empty. Reset sets the threshold to 1.0, both rules to their third code,
// clears the running totals (not the output registers) and empties the pipeline.
module risk_cell_classifier #(
	parameter int COUNT_BITS      = 20,
	parameter int TOTAL_BITS      = 32,
	parameter int CELL_INDEX_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  rcc_pkg::reg_index_t                  cfg_index,
	input  logic [rcc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [CELL_INDEX_BITS-1:0]           cell_index,
	input  logic [COUNT_BITS-1:0]                train_unaffected,
	input  logic [COUNT_BITS-1:0]                train_affected,
	input  logic [COUNT_BITS-1:0]                test_unaffected,
	input  logic [COUNT_BITS-1:0]                test_affected,
	input  logic                                 last_cell,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [CELL_INDEX_BITS-1:0]           cell_id,
	output rcc_pkg::status_t                     risk_status,
	output logic [TOTAL_BITS-1:0]                class_high_total,
	output logic [TOTAL_BITS-1:0]                misclass_high_total,
	output logic [TOTAL_BITS-1:0]                class_low_total,
	output logic [TOTAL_BITS-1:0]                misclass_low_total,
	output logic                                 final_result
);
	import rcc_pkg::*;

	`include "assert_macros.svh"

	logic [THRESHOLD_BITS-1:0] threshold_q;
	rule_t                     tie_rule_q;
	rule_t                     empty_rule_q;

	logic                       v_s1, v_s2, out_valid_q;
	logic                       in_accept, adv_s2, adv_out;

	logic [CELL_INDEX_BITS-1:0] id_s1;
	logic [COUNT_BITS-1:0]      tr_u_s1, tr_a_s1, te_u_s1, te_a_s1;
	logic                       last_s1;

	class_t                     cls;
	class_t                     cls_s2;
	logic [CELL_INDEX_BITS-1:0] id_s2;
	logic [COUNT_BITS-1:0]      te_u_s2, te_a_s2;
	logic                       last_s2;

	logic [CELL_INDEX_BITS-1:0] cell_id_q;
	status_t                    status_q;
	logic                       final_q;

	// configuration registers, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RESET;
			tie_rule_q   <= TIE_RULE_RESET;
			empty_rule_q <= EMPTY_RULE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_THRESHOLD:  threshold_q  <= cfg_data[THRESHOLD_BITS-1:0];
				REG_TIE_RULE:   tie_rule_q   <= cfg_data[RULE_BITS-1:0];
				REG_EMPTY_RULE: empty_rule_q <= cfg_data[RULE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// each stage moves when the one after it is empty or moving
	assign adv_out   = v_s2 && (!out_valid_q || out_ready);
	assign adv_s2    = v_s1 && (!v_s2 || adv_out);
	assign in_ready  = !v_s1 || adv_s2;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				v_s1 <= 1'b1;
			end else if (adv_s2) begin
				v_s1 <= 1'b0;
			end
			if (adv_s2) begin
				v_s2 <= 1'b1;
			end else if (adv_out) begin
				v_s2 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			id_s1   <= cell_index;
			tr_u_s1 <= train_unaffected;
			tr_a_s1 <= train_affected;
			te_u_s1 <= test_unaffected;
			te_a_s1 <= test_affected;
			last_s1 <= last_cell;
		end
	end

	rcc_classify #(
		.COUNT_BITS(COUNT_BITS)
	) u_classify (
		.threshold       (threshold_q),
		.tie_rule        (tie_rule_q),
		.empty_rule      (empty_rule_q),
		.train_unaffected(tr_u_s1),
		.train_affected  (tr_a_s1),
		.cls             (cls)
	);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			cls_s2  <= cls;
			id_s2   <= id_s1;
			te_u_s2 <= te_u_s1;
			te_a_s2 <= te_a_s1;
			last_s2 <= last_s1;
		end
	end

	rcc_totals #(
		.COUNT_BITS(COUNT_BITS),
		.TOTAL_BITS(TOTAL_BITS)
	) u_totals (
		.clk                (clk),
		.arst_n             (arst_n),
		.load               (adv_out),
		.cls                (cls_s2),
		.test_unaffected    (te_u_s2),
		.test_affected      (te_a_s2),
		.last               (last_s2),
		.class_high_total   (class_high_total),
		.misclass_high_total(misclass_high_total),
		.class_low_total    (class_low_total),
		.misclass_low_total (misclass_low_total)
	);

	always_ff @(posedge clk) begin
		if (adv_out) begin
			cell_id_q <= id_s2;
			status_q  <= cls_s2.status;
			final_q   <= last_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign cell_id      = cell_id_q;
	assign risk_status  = status_q;
	assign final_result = final_q;

	`RCC_ASSERT(a_full_blocks_input, (v_s1 && v_s2 && out_valid_q && !out_ready) |-> !in_ready, "input taken with every stage full and output stalled")
	`RCC_ASSERT(a_no_phantom_result, (!v_s2 && (!out_valid_q || out_ready)) |=> !out_valid_q, "result shown without a cell in the classification stage")
	`RCC_ASSERT(a_single_class, v_s2 |-> !(cls_s2.add_high && cls_s2.add_low) && !((cls_s2.status == STATUS_TIE) && (cls_s2.add_high || cls_s2.add_low)), "cell counted in both classes or a tie counted")
	`RCC_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid && !v_s1 && !v_s2, "pipeline not empty in reset")

endmodule
